### hdl/krb_pkg.sv
// Shared widths, defaults and operation codes for the keyed ring buffer.
package krb_pkg;

   // Fixed field widths.
   localparam int KEY_W  = 32;
   localparam int SLOT_W = 8;
   localparam int MODE_W = 2;
   localparam int FILL_W = 9;

   // Parameter defaults.
   localparam int DEPTH_DEFAULT      = 256;
   localparam int DATA_WIDTH_DEFAULT = 64;

   // Capacity after reset, before clamping to the depth.
   localparam int CAP_RESET = 256;

   // Operation codes carried in the request's tuser.
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd3;

endpackage

### hdl/keyed_ring_buffer.sv
// Keyed ring buffer: slot store with sequence keys, key search sequencer and output register.
//
// The block holds up to capacity entries, each a data word and a 32-bit sequence key, in two
// memories of DEPTH slots with one registered read port and one write port. It takes one item at a
// time: an append passes from acceptance through the slot read and the write state to the result
// register, a read at a slot through the slot read, and a get or write by key through a search that
// walks the stored keys one slot per cycle through the key memory's single read port and one shared
// comparator. The next item is accepted as soon as the sequencer is back in idle, even while the
// previous result still waits in the output register. A write on the csr port sets the capacity
// (0 acts as 1, values above the depth act as the depth) and empties the store; the key counter
// keeps running.
module keyed_ring_buffer #(
   parameter int DEPTH      = krb_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = krb_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,

   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // key_in, slot_index, data_in, zero pad
   input  logic [((krb_pkg::KEY_W + krb_pkg::SLOT_W + DATA_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // mode
   input  logic [krb_pkg::MODE_W-1:0]            req_tuser,
   input  logic                                  req_tlast,

   // Response channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // new_key, evicted_key, key_out, data_out, fill_count, zero pad
   output logic [((3 * krb_pkg::KEY_W + DATA_WIDTH + krb_pkg::FILL_W + 7) / 8) * 8 - 1:0]
                                                 rsp_tdata,
   // evicted_valid, found
   output logic [1:0]                            rsp_tuser,
   output logic                                  rsp_tlast,

   // Capacity register write port.
   input  logic                                  csr_wen,
   input  logic [krb_pkg::FILL_W-1:0]            csr_wdata
);

   localparam int KEY_W       = krb_pkg::KEY_W;
   localparam int SLOT_W      = krb_pkg::SLOT_W;
   localparam int FILL_W      = krb_pkg::FILL_W;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int OUT_TDATA_W = ((3 * KEY_W + DATA_WIDTH + FILL_W + 7) / 8) * 8;
   localparam int CAP_MAX     = (DEPTH > (2 ** FILL_W - 1)) ? (2 ** FILL_W - 1) : DEPTH;
   localparam int CAP_INIT    = (DEPTH < krb_pkg::CAP_RESET) ? DEPTH : krb_pkg::CAP_RESET;
   localparam logic [FILL_W-1:0] CAP_LIMIT = FILL_W'(CAP_MAX);
   localparam logic [FILL_W-1:0] CAP_RST   = FILL_W'(CAP_INIT);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_APP  = 3'd1;
   localparam logic [2:0] ST_SLOT = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0]      new_key;
      logic                  evicted_valid;
      logic [KEY_W-1:0]      evicted_key;
      logic                  found;
      logic [KEY_W-1:0]      key_out;
      logic [DATA_WIDTH-1:0] data_out;
      logic [FILL_W-1:0]     fill_count;
      logic                  batch_end;
   } rsp_type;

   // Slot memories and registered read data.
   logic [KEY_W-1:0]      key_mem_ff  [DEPTH];
   logic [DATA_WIDTH-1:0] data_mem_ff [DEPTH];
   logic [KEY_W-1:0]      key_rd_ff;
   logic [DATA_WIDTH-1:0] data_rd_ff;

   // Control state.
   logic [2:0]        state_ff, state_in;
   logic [FILL_W-1:0] cap_ff, cap_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] cursor_ff, cursor_in;
   logic [KEY_W-1:0]  kc_ff, kc_in;
   logic [FILL_W-1:0] scan_ff, scan_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [FILL_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Latched request and result payload.
   logic [krb_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [KEY_W-1:0]           key_ff, key_in;
   logic [DATA_WIDTH-1:0]      data_ff, data_in;
   rsp_type                    res_ff, res_in;
   rsp_type                    rsp_ff, rsp_in;

   // Memory port controls.
   logic              key_we;
   logic              data_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;

   // Request field unpacking.
   logic [KEY_W-1:0]      in_key;
   logic [SLOT_W-1:0]     in_slot;
   logic [DATA_WIDTH-1:0] in_data;
   logic                  req_fire;
   logic [FILL_W-1:0]     app_pos;
   logic [FILL_W-1:0]     app_pos_next;
   logic                  full;
   logic                  hit;
   logic                  out_free;
   logic [FILL_W-1:0]     cap_eff;

   assign in_key   = req_tdata[KEY_W-1:0];
   assign in_slot  = req_tdata[KEY_W+SLOT_W-1:KEY_W];
   assign in_data  = req_tdata[KEY_W+SLOT_W+DATA_WIDTH-1:KEY_W+SLOT_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Append position and the wrapped cursor after it.
   assign app_pos      = (cursor_ff >= cap_ff) ? '0 : cursor_ff;
   assign app_pos_next = (app_pos + 1'b1 >= cap_ff) ? '0 : app_pos + 1'b1;
   assign full         = (fill_ff >= cap_ff);

   // Shared key comparator for the search.
   assign hit = cmp_vld_ff && (key_rd_ff == key_ff);

   // Clamp a written capacity into the usable range.
   always_comb begin
      if (csr_wdata == '0) begin
         cap_eff = FILL_W'(1);
      end else if (csr_wdata > CAP_LIMIT) begin
         cap_eff = CAP_LIMIT;
      end else begin
         cap_eff = csr_wdata;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      fill_in      = fill_ff;
      cursor_in    = cursor_ff;
      kc_in        = kc_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      data_in      = data_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      key_we       = 1'b0;
      data_we      = 1'b0;
      mem_waddr    = ADDR_W'(app_pos);
      mem_raddr    = ADDR_W'(app_pos);

      case (state_ff)
         ST_IDLE: begin
            // Start the slot read for an append or a read at a slot right away.
            if (req_tuser == krb_pkg::MODE_READ) begin
               mem_raddr = ADDR_W'(in_slot);
            end
            if (req_fire) begin
               mode_in = req_tuser;
               key_in  = in_key;
               data_in = in_data;
               scan_in = '0;
               res_in  = '0;
               res_in.batch_end  = req_tlast;
               res_in.fill_count = fill_ff;
               case (req_tuser)
                  krb_pkg::MODE_APPEND: begin
                     state_in = ST_APP;
                  end
                  krb_pkg::MODE_READ: begin
                     if ({1'b0, in_slot} < fill_ff) begin
                        state_in = ST_SLOT;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end

         ST_APP: begin
            // Write the new entry and report any entry it replaces.
            key_we    = 1'b1;
            data_we   = 1'b1;
            mem_waddr = ADDR_W'(app_pos);
            cursor_in = app_pos_next;
            kc_in     = kc_ff + 1'b1;
            res_in.new_key = kc_ff;
            if (full) begin
               res_in.evicted_valid = 1'b1;
               res_in.evicted_key   = key_rd_ff;
               res_in.fill_count    = fill_ff;
            end else begin
               fill_in           = fill_ff + 1'b1;
               res_in.fill_count = fill_ff + 1'b1;
            end
            state_in = ST_DONE;
         end

         ST_SLOT: begin
            res_in.found    = 1'b1;
            res_in.key_out  = key_rd_ff;
            res_in.data_out = data_rd_ff;
            state_in        = ST_DONE;
         end

         ST_SCAN: begin
            // One slot read and one key compare per cycle, lowest slot first.
            mem_raddr = ADDR_W'(scan_ff);
            mem_waddr = ADDR_W'(cmp_idx_ff);
            if (hit) begin
               res_in.found = 1'b1;
               if (mode_ff == krb_pkg::MODE_WRITE) begin
                  data_we         = 1'b1;
                  res_in.data_out = data_ff;
               end else begin
                  res_in.data_out = data_rd_ff;
               end
               state_in = ST_DONE;
            end else if (scan_ff < fill_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff;
               scan_in    = scan_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A capacity write empties the store; the user must issue it only while idle, as the block does not enforce this.
      if (csr_wen) begin
         cap_in    = cap_eff;
         fill_in   = '0;
         cursor_in = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RST;
         fill_ff      <= '0;
         cursor_ff    <= '0;
         kc_ff        <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
         cursor_ff    <= cursor_in;
         kc_ff        <= kc_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      mode_ff    <= mode_in;
      key_ff     <= key_in;
      data_ff    <= data_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   // Slot memories with registered read.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[mem_waddr] <= kc_ff;
      end
      if (data_we) begin
         data_mem_ff[mem_waddr] <= data_ff;
      end
      key_rd_ff  <= key_mem_ff[mem_raddr];
      data_rd_ff <= data_mem_ff[mem_raddr];
   end

   // Response packing.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_TDATA_W'({rsp_ff.fill_count, rsp_ff.data_out, rsp_ff.key_out,
                                     rsp_ff.evicted_key, rsp_ff.new_key});
   assign rsp_tuser  = {rsp_ff.found, rsp_ff.evicted_valid};
   assign rsp_tlast  = rsp_ff.batch_end;

   // The store never holds more entries than the capacity allows.
   assert property (@(posedge clock) disable iff (reset) fill_ff <= cap_ff)
      else $error("fill count exceeds capacity");

   // Until the store wraps, the cursor sits right behind the newest entry.
   assert property (@(posedge clock) disable iff (reset)
                    (fill_ff < cap_ff) |-> (cursor_ff == fill_ff))
      else $error("write cursor out of step with fill count");

   // Every append consumes exactly one key.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_APP) |=> (kc_ff == $past(kc_ff) + 1'b1))
      else $error("key counter did not advance on append");

   // A key match is only taken from a slot that holds a valid entry.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_SCAN && hit) |-> (cmp_idx_ff < fill_ff))
      else $error("search matched beyond the filled slots");

   // A finished result waits while the output register is still occupied.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_DONE && !out_free) |=> (state_ff == ST_DONE))
      else $error("result left the sequencer while the output was busy");

endmodule

### test/keyed_ring_buffer_tb.sv
// Self-checking testbench for the keyed ring buffer: directed and random items with a scoreboard.
`timescale 1ns / 100ps

module keyed_ring_buffer_tb;

   localparam int REQ_W = ((krb_pkg::KEY_W + krb_pkg::SLOT_W + 64 + 7) / 8) * 8;
   localparam int RSP_W = ((3 * krb_pkg::KEY_W + 64 + krb_pkg::FILL_W + 7) / 8) * 8;
   localparam int SLOTS = krb_pkg::DEPTH_DEFAULT;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // key_in, slot_index, data_in
   logic [REQ_W-1:0] req_tdata;
   // mode
   logic [krb_pkg::MODE_W-1:0] req_tuser;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   // new_key, evicted_key, key_out, data_out, fill_count, zero pad
   logic [RSP_W-1:0] rsp_tdata;
   // evicted_valid, found
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_wen;
   logic [krb_pkg::FILL_W-1:0] csr_wdata;

   // High during the stretch of the run in which neither side idles.
   bit no_gaps;

   // One expected response item, field by field.
   typedef struct packed {
      logic [31:0] new_key;
      logic        evicted_valid;
      logic [31:0] evicted_key;
      logic        found;
      logic [31:0] key_out;
      logic [63:0] data_out;
      logic [8:0]  fill_count;
      logic        batch_end;
   } ring_result_type;

   // Tracks the ring contents and holds the responses still owed by the block.
   class ring_scoreboard;
      logic [8:0]      capacity;
      logic [31:0]     slot_key [SLOTS];
      logic [63:0]     slot_data [SLOTS];
      int unsigned     fill;
      int unsigned     cursor;
      logic [31:0]     key_count;
      ring_result_type expected_q[$];
      int unsigned     errors;

      function new();
         capacity  = 9'(krb_pkg::CAP_RESET);
         fill      = 0;
         cursor    = 0;
         key_count = 0;
         errors    = 0;
      endfunction

      // A capacity write empties the ring but keeps the key counter running.
      function void set_capacity(logic [8:0] value);
         capacity = value;
         fill     = 0;
         cursor   = 0;
      endfunction

      // Zero behaves as one slot and anything above the depth as the full depth.
      function int unsigned live_capacity();
         if (capacity == 0) return 1;
         if (capacity > SLOTS) return SLOTS;
         return 32'(capacity);
      endfunction

      // Lowest occupied slot holding the key, or -1 when the key is absent.
      function int find_slot(logic [31:0] key);
         for (int i = 0; i < fill; i++) begin
            if (slot_key[8'(i)] == key) return i;
         end
         return -1;
      endfunction

      // Applies one accepted request item to the ring and queues its response.
      function void note_request(logic [1:0] mode, logic [31:0] key, logic [7:0] slot,
                                 logic [63:0] data, logic last);
         ring_result_type r;
         int unsigned     cap;
         int unsigned     pos;
         int              hit;
         r = '0;
         cap = live_capacity();
         r.batch_end = last;
         case (mode)
            krb_pkg::MODE_APPEND: begin
               pos = (cursor >= cap) ? 0 : cursor;
               r.new_key = key_count;
               if (fill < cap) begin
                  fill++;
               end else begin
                  r.evicted_valid = 1'b1;
                  r.evicted_key   = slot_key[8'(pos)];
               end
               slot_key[8'(pos)]  = key_count;
               slot_data[8'(pos)] = data;
               cursor = (pos + 1 >= cap) ? 0 : pos + 1;
               key_count++;
            end
            krb_pkg::MODE_GET: begin
               hit = find_slot(key);
               if (hit >= 0) begin
                  r.found    = 1'b1;
                  r.data_out = slot_data[8'(hit)];
               end
            end
            krb_pkg::MODE_READ: begin
               if (slot < fill) begin
                  r.found    = 1'b1;
                  r.key_out  = slot_key[slot];
                  r.data_out = slot_data[slot];
               end
            end
            default: begin
               // Write by key only touches an entry that is present.
               hit = find_slot(key);
               if (hit >= 0) begin
                  slot_data[8'(hit)] = data;
                  r.found    = 1'b1;
                  r.data_out = data;
               end
            end
         endcase
         r.fill_count = fill[8:0];
         expected_q = {expected_q, r};
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
         errors++;
      endtask

      // Compares one accepted response item with the oldest expectation.
      task check_response(logic [RSP_W-1:0] tdata, logic [1:0] tuser, logic tlast);
         ring_result_type want;
         if (expected_q.size() == 0) begin
            report("response with nothing pending", tdata[63:0], 64'd0);
            return;
         end
         want = expected_q.pop_front();
         if (tdata[31:0] !== want.new_key)
            report("new_key", 64'(tdata[31:0]), 64'(want.new_key));
         if (tuser[0] !== want.evicted_valid)
            report("evicted_valid", 64'(tuser[0]), 64'(want.evicted_valid));
         if (tdata[63:32] !== want.evicted_key)
            report("evicted_key", 64'(tdata[63:32]), 64'(want.evicted_key));
         if (tuser[1] !== want.found)
            report("found", 64'(tuser[1]), 64'(want.found));
         if (tdata[95:64] !== want.key_out)
            report("key_out", 64'(tdata[95:64]), 64'(want.key_out));
         if (tdata[159:96] !== want.data_out)
            report("data_out", tdata[159:96], want.data_out);
         if (tdata[168:160] !== want.fill_count)
            report("fill_count", 64'(tdata[168:160]), 64'(want.fill_count));
         if (tlast !== want.batch_end)
            report("batch_end", 64'(tlast), 64'(want.batch_end));
      endtask
   endclass

   ring_scoreboard book;

   keyed_ring_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // The response side stalls now and then, except in the gap-free stretch.
   always @(posedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(99) >= 15);
   end

   // Every accepted response item goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         book.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Offers one request item, with random idle cycles ahead of it, and waits for acceptance.
   task send_item(logic [1:0] mode, logic [31:0] key, logic [7:0] slot, logic [63:0] data,
                  logic last);
      while (!no_gaps && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tlast  <= last;
      req_tdata  <= {data, slot, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_request(mode, key, slot, data, last);
   endtask

   // Stops sending and waits until every owed response item has come back.
   task drain();
      req_tvalid <= 1'b0;
      while (book.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task write_capacity(logic [8:0] value);
      drain();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      book.set_capacity(value);
   endtask

   // Run limit, far above the slowest correct run.
   initial begin
      #4000000;
      $display("keyed_ring_buffer_tb failed");
      $finish;
   end

   initial begin
      logic [8:0]  caps [10];
      logic [1:0]  mode;
      logic [31:0] key;
      logic [7:0]  slot;
      int          pick;
      int          count;
      bit          deep;

      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = krb_pkg::MODE_APPEND;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_wen    = 1'b0;
      csr_wdata  = '0;
      no_gaps    = 1'b0;
      book = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty ring: lookups miss and a write to an absent key changes nothing.
      send_item(krb_pkg::MODE_GET, 32'd0, 8'd0, 64'd0, 1'b0);
      send_item(krb_pkg::MODE_READ, 32'd0, 8'd0, 64'd0, 1'b1);
      send_item(krb_pkg::MODE_WRITE, 32'd0, 8'd0, '1, 1'b0);

      // A few appends with extreme payloads, then hits and misses.
      send_item(krb_pkg::MODE_APPEND, '1, 8'hff, 64'd0, 1'b0);
      send_item(krb_pkg::MODE_APPEND, 32'd0, 8'd0, '1, 1'b1);
      send_item(krb_pkg::MODE_APPEND, 32'd0, 8'd0, 64'h0123_4567_89ab_cdef, 1'b0);
      send_item(krb_pkg::MODE_GET, 32'd1, 8'd0, 64'd0, 1'b0);
      send_item(krb_pkg::MODE_GET, '1, 8'd0, 64'd0, 1'b1);
      send_item(krb_pkg::MODE_READ, 32'd0, 8'd2, 64'd0, 1'b0);
      send_item(krb_pkg::MODE_READ, 32'd0, 8'd3, 64'd0, 1'b0);
      send_item(krb_pkg::MODE_READ, 32'd0, 8'hff, 64'd0, 1'b0);
      send_item(krb_pkg::MODE_WRITE, 32'd2, 8'd0, 64'd0, 1'b1);
      send_item(krb_pkg::MODE_GET, 32'd2, 8'd0, 64'd0, 1'b0);
      send_item(krb_pkg::MODE_WRITE, '1, 8'd0, '1, 1'b0);

      // Small capacity: the third append evicts the oldest key.
      write_capacity(9'd2);
      repeat (3) send_item(krb_pkg::MODE_APPEND, 32'd0, 8'd0, {$urandom, $urandom}, 1'b0);
      send_item(krb_pkg::MODE_GET, 32'd3, 8'd0, 64'd0, 1'b0);
      send_item(krb_pkg::MODE_READ, 32'd0, 8'd0, 64'd0, 1'b0);
      send_item(krb_pkg::MODE_READ, 32'd0, 8'd1, 64'd0, 1'b1);

      // Zero capacity holds one entry; an oversize value acts as the full depth.
      write_capacity(9'd0);
      repeat (2) send_item(krb_pkg::MODE_APPEND, 32'd0, 8'd0, {$urandom, $urandom}, 1'b0);
      send_item(krb_pkg::MODE_READ, 32'd0, 8'd0, 64'd0, 1'b0);
      write_capacity(9'h1ff);
      send_item(krb_pkg::MODE_APPEND, 32'd0, 8'd0, {$urandom, $urandom}, 1'b1);
      send_item(krb_pkg::MODE_READ, 32'd0, 8'd0, 64'd0, 1'b0);

      // Random phases, one capacity each; the phase with capacity 1ff fills the whole depth.
      caps = '{9'd3, 9'd1, 9'd16, 9'h1ff, 9'd0, 9'd300, 9'd7, 9'd256,
               9'($urandom_range(4, 64)), 9'd2};
      for (int ph = 0; ph < 10; ph++) begin
         write_capacity(caps[4'(ph)]);
         deep    = (caps[4'(ph)] == 9'h1ff);
         no_gaps = (ph == 4);
         count   = deep ? 400 : 50;
         for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < (deep ? 75 : 40))
               mode = krb_pkg::MODE_APPEND;
            else if (pick < (deep ? 85 : 65))
               mode = krb_pkg::MODE_GET;
            else if (pick < (deep ? 92 : 80))
               mode = krb_pkg::MODE_READ;
            else
               mode = krb_pkg::MODE_WRITE;
            // Mostly recent keys, some just evicted, the rest arbitrary.
            if ($urandom_range(99) < 80 && book.key_count != 0)
               key = book.key_count - 1 - $urandom_range(0, book.live_capacity() + 2);
            else
               key = $urandom;
            if ($urandom_range(99) < 70)
               slot = 8'($urandom_range(0, book.fill));
            else
               slot = 8'($urandom_range(255));
            send_item(mode, key, slot, {$urandom, $urandom}, 1'($urandom_range(1)));
         end
      end
      no_gaps = 1'b0;

      drain();
      repeat (300) @(posedge clock);
      if (book.errors == 0 && book.expected_q.size() == 0) begin
         $display("keyed_ring_buffer_tb passed");
      end else begin
         $display("keyed_ring_buffer_tb failed");
      end
      $finish;
   end

endmodule

### files.f
hdl/krb_pkg.sv
hdl/keyed_ring_buffer.sv
test/keyed_ring_buffer_tb.sv
